FILE: rtl/erc_pkg.sv
// erc_pkg: shared constants, op and status codes, controller/datapath structs
// for the epoch reclamation engine. No dependencies.
`timescale 1ns / 1ps

package erc_pkg;

	localparam int THREAD_SLOTS_DEF = 64;
	localparam int POOL_NODES_DEF   = 64;
	localparam int NUM_BUCKETS      = 3;
	localparam int MAX_RESULTS      = 64;
	localparam int NW               = $clog2(MAX_RESULTS + 1);

	localparam int OP_W     = 3;
	localparam int SLOT_W   = 6;
	localparam int HANDLE_W = 48;
	localparam int TAG_W    = 16;
	localparam int STAT_W   = 2;
	localparam int EPOCH_W  = 31;
	localparam int DROP_W   = 32;

	localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
	localparam logic [OP_W-1:0] OP_ENTER      = 3'd2;
	localparam logic [OP_W-1:0] OP_EXIT       = 3'd3;
	localparam logic [OP_W-1:0] OP_RETIRE     = 3'd4;
	localparam logic [OP_W-1:0] OP_FLUSH      = 3'd5;
	localparam logic [OP_W-1:0] OP_SHUTDOWN   = 3'd6;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;
	localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd3;

	typedef struct packed {
		logic latch;
		logic exec;
		logic scan;
		logic advance;
		logic set_blocked;
		logic drain_rd;
		logic drain_emit;
		logic drain_close;
		logic ret_commit;
		logic emit_single;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ret_alloc;
		logic            scan_busy;
		logic            blocked;
		logic            live;
		logic            more;
		logic            n_zero;
		logic            out_free;
	} sts_t;

endpackage

FILE: rtl/erc_if.sv
// erc_req_if / erc_rsp_if: valid/ready channels for requests and results.
// Depends on erc_pkg for field widths.
`timescale 1ns / 1ps

interface erc_req_if;
	logic                          valid;
	logic                          ready;
	logic [erc_pkg::OP_W-1:0]     op;
	logic [erc_pkg::SLOT_W-1:0]   thread_slot;
	logic [erc_pkg::HANDLE_W-1:0] handle;
	logic [erc_pkg::TAG_W-1:0]    cleanup_tag;
	modport source(output valid, op, thread_slot, handle, cleanup_tag, input ready);
	modport sink(input valid, op, thread_slot, handle, cleanup_tag, output ready);
endinterface

interface erc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [erc_pkg::STAT_W-1:0]   status;
	logic                          reclaim_valid;
	logic [erc_pkg::HANDLE_W-1:0] reclaimed_handle;
	logic [erc_pkg::TAG_W-1:0]    reclaimed_tag;
	logic                          last;
	logic                          epoch_advanced;
	logic [erc_pkg::EPOCH_W-1:0]  current_epoch;
	logic [erc_pkg::DROP_W-1:0]   dropped_count;
	modport source(output valid, status, reclaim_valid, reclaimed_handle, reclaimed_tag,
		last, epoch_advanced, current_epoch, dropped_count, input ready);
	modport sink(input valid, status, reclaim_valid, reclaimed_handle, reclaimed_tag,
		last, epoch_advanced, current_epoch, dropped_count, output ready);
endinterface

FILE: rtl/erc_ram.sv
// erc_ram: generic one-write one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module erc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                     wdata,
	input  logic                             re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                     rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/erc_dp.sv
// erc_dp: datapath of the reclamation engine: slot state, epoch, node pool
// lists, announce and node RAMs, result register. Uses erc_pkg, erc_ram, erc_rsp_if.
`timescale 1ns / 1ps

module erc_dp #(
	parameter int THREAD_SLOTS = erc_pkg::THREAD_SLOTS_DEF,
	parameter int POOL_NODES   = erc_pkg::POOL_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [erc_pkg::OP_W-1:0]     op,
	input  logic [erc_pkg::SLOT_W-1:0]   thread_slot,
	input  logic [erc_pkg::HANDLE_W-1:0] handle,
	input  logic [erc_pkg::TAG_W-1:0]    cleanup_tag,
	input  erc_pkg::cmd_t                 cmd,
	output erc_pkg::sts_t                 sts,
	erc_rsp_if.source                     rsp
);
	localparam int SW   = THREAD_SLOTS > 1 ? $clog2(THREAD_SLOTS) : 1;
	localparam int SCW  = $clog2(THREAD_SLOTS + 1);
	localparam int PAW  = $clog2(POOL_NODES);
	localparam int IDXW = $clog2(POOL_NODES + 1);
	localparam logic [IDXW-1:0] NULLN = IDXW'(POOL_NODES);
	localparam int DW   = erc_pkg::HANDLE_W + erc_pkg::TAG_W;

	logic [erc_pkg::OP_W-1:0]     op_q;
	logic [erc_pkg::SLOT_W-1:0]   slot_q;
	logic [erc_pkg::HANDLE_W-1:0] handle_q;
	logic [erc_pkg::TAG_W-1:0]    tag_q;

	logic [THREAD_SLOTS-1:0] reg_q;
	logic [THREAD_SLOTS-1:0] rd_q;
	logic [erc_pkg::EPOCH_W-1:0] epoch_q;
	logic [1:0]                  bkt_q;
	logic [erc_pkg::DROP_W-1:0]  drop_q;
	logic [IDXW-1:0] free_q;
	logic [IDXW-1:0] fresh_q;
	logic [IDXW-1:0] bhead_q [erc_pkg::NUM_BUCKETS];
	logic [IDXW-1:0] cur_q;
	logic [1:0]      bsel_q;
	logic [erc_pkg::NW-1:0] n_q;
	logic [erc_pkg::STAT_W-1:0] st_q;
	logic adv_q;

	logic [SCW-1:0] scan_q;
	logic [SW-1:0]  idx_s1;
	logic           pend_s1;
	logic           blocked_q;

	logic                          ovalid_q;
	logic [erc_pkg::STAT_W-1:0]   ostat_q;
	logic                          orv_q;
	logic [erc_pkg::HANDLE_W-1:0] oh_q;
	logic [erc_pkg::TAG_W-1:0]    ot_q;
	logic                          olast_q;
	logic                          oadv_q;
	logic [erc_pkg::EPOCH_W-1:0]  oep_q;
	logic [erc_pkg::DROP_W-1:0]   odrop_q;

	logic [8:0]    slot_x;
	logic [SW-1:0] slot_ix;
	logic          slot_ok;
	logic          slot_reg;
	logic          free_null;
	logic          fresh_node;
	logic [IDXW-1:0] ret_next;

	logic           ann_we;
	logic           ann_re;
	logic [erc_pkg::EPOCH_W-1:0] ann_rd;
	logic           link_we;
	logic [PAW-1:0] link_waddr;
	logic [IDXW-1:0] link_wdata;
	logic           link_re;
	logic [PAW-1:0] link_raddr;
	logic [IDXW-1:0] link_rd;
	logic [DW-1:0]  data_rd;

	logic          nxt_null;
	logic          rest_null;
	logic          drain_last;
	logic [1:0]    bsel_nx;

	assign slot_x     = {3'b000, slot_q};
	assign slot_ix    = slot_x[SW-1:0];
	assign slot_ok    = slot_x < 9'(THREAD_SLOTS);
	assign slot_reg   = slot_ok && reg_q[slot_ix];
	assign free_null  = free_q >= NULLN;
	assign fresh_node = free_q < fresh_q;
	assign ret_next   = fresh_node ? ((free_q == '0) ? NULLN : free_q - 1'b1) : link_rd;
	assign nxt_null   = link_rd >= NULLN;
	assign bsel_nx    = bsel_q + 2'd1;

	always_comb begin
		unique case (bsel_q)
			2'd0:    rest_null = bhead_q[1] >= NULLN && bhead_q[2] >= NULLN;
			2'd1:    rest_null = bhead_q[2] >= NULLN;
			default: rest_null = 1'b1;
		endcase
	end

	assign drain_last = (n_q == erc_pkg::NW'(erc_pkg::MAX_RESULTS - 1)) ||
		(nxt_null && (op_q != erc_pkg::OP_SHUTDOWN || rest_null));

	assign ann_we = cmd.exec && op_q == erc_pkg::OP_ENTER && slot_reg;
	assign ann_re = cmd.scan && scan_q < SCW'(THREAD_SLOTS);

	assign link_re    = (cmd.exec && op_q == erc_pkg::OP_RETIRE) || cmd.drain_rd;
	assign link_raddr = cmd.drain_rd ? cur_q[PAW-1:0] : free_q[PAW-1:0];
	assign link_we    = cmd.ret_commit || cmd.drain_emit;
	assign link_waddr = cmd.drain_emit ? cur_q[PAW-1:0] : free_q[PAW-1:0];
	assign link_wdata = cmd.drain_emit ? free_q : bhead_q[bkt_q];

	erc_ram #(.W(erc_pkg::EPOCH_W), .D(THREAD_SLOTS)) u_ann (
		.clk(clk), .we(ann_we), .waddr(slot_ix), .wdata(epoch_q),
		.re(ann_re), .raddr(scan_q[SW-1:0]), .rdata(ann_rd)
	);

	erc_ram #(.W(IDXW), .D(POOL_NODES)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(link_re), .raddr(link_raddr), .rdata(link_rd)
	);

	erc_ram #(.W(DW), .D(POOL_NODES)) u_node (
		.clk(clk), .we(cmd.ret_commit), .waddr(free_q[PAW-1:0]), .wdata({handle_q, tag_q}),
		.re(cmd.drain_rd), .raddr(cur_q[PAW-1:0]), .rdata(data_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= op;
			slot_q   <= thread_slot;
			handle_q <= handle;
			tag_q    <= cleanup_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q     <= '0;
			rd_q      <= '0;
			epoch_q   <= '0;
			bkt_q     <= '0;
			drop_q    <= '0;
			free_q    <= IDXW'(POOL_NODES - 1);
			fresh_q   <= NULLN;
			for (int i = 0; i < erc_pkg::NUM_BUCKETS; i++) begin
				bhead_q[i] <= NULLN;
			end
			cur_q     <= NULLN;
			bsel_q    <= '0;
			n_q       <= '0;
			st_q      <= erc_pkg::ST_DONE;
			adv_q     <= 1'b0;
			scan_q    <= '0;
			idx_s1    <= '0;
			pend_s1   <= 1'b0;
			blocked_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				adv_q <= 1'b0;
				n_q   <= '0;
				unique case (op_q)
					erc_pkg::OP_REGISTER: begin
						if (slot_ok && !reg_q[slot_ix]) begin
							reg_q[slot_ix] <= 1'b1;
							rd_q[slot_ix]  <= 1'b0;
							st_q           <= erc_pkg::ST_DONE;
						end else begin
							st_q <= erc_pkg::ST_IGNORED;
						end
					end
					erc_pkg::OP_UNREGISTER: begin
						if (slot_reg) begin
							reg_q[slot_ix] <= 1'b0;
							rd_q[slot_ix]  <= 1'b0;
							st_q           <= erc_pkg::ST_DONE;
						end else begin
							st_q <= erc_pkg::ST_IGNORED;
						end
					end
					erc_pkg::OP_ENTER: begin
						if (slot_reg) begin
							rd_q[slot_ix] <= 1'b1;
							st_q          <= erc_pkg::ST_DONE;
						end else begin
							st_q <= erc_pkg::ST_IGNORED;
						end
					end
					erc_pkg::OP_EXIT: begin
						if (slot_reg) begin
							rd_q[slot_ix] <= 1'b0;
							st_q          <= erc_pkg::ST_DONE;
						end else begin
							st_q <= erc_pkg::ST_IGNORED;
						end
					end
					erc_pkg::OP_RETIRE: begin
						if (handle_q == '0) begin
							st_q <= erc_pkg::ST_IGNORED;
						end else if (free_null) begin
							if (drop_q != '1) begin
								drop_q <= drop_q + 1'b1;
							end
							st_q <= erc_pkg::ST_DROPPED;
						end else begin
							st_q <= erc_pkg::ST_DONE;
						end
					end
					erc_pkg::OP_FLUSH: begin
						st_q      <= erc_pkg::ST_DONE;
						scan_q    <= '0;
						pend_s1   <= 1'b0;
						blocked_q <= 1'b0;
					end
					erc_pkg::OP_SHUTDOWN: begin
						st_q   <= erc_pkg::ST_DONE;
						reg_q  <= '0;
						rd_q   <= '0;
						bsel_q <= 2'd0;
						cur_q  <= bhead_q[0];
					end
					default: st_q <= erc_pkg::ST_IGNORED;
				endcase
			end
			if (cmd.scan) begin
				pend_s1 <= ann_re;
				idx_s1  <= scan_q[SW-1:0];
				if (ann_re) begin
					scan_q <= scan_q + 1'b1;
				end
				if (pend_s1 && reg_q[idx_s1] && rd_q[idx_s1] && ann_rd != epoch_q) begin
					blocked_q <= 1'b1;
				end
			end
			if (cmd.set_blocked) begin
				st_q <= erc_pkg::ST_BLOCKED;
			end
			if (cmd.advance) begin
				epoch_q <= epoch_q + 1'b1;
				adv_q   <= 1'b1;
				unique case (bkt_q)
					2'd0: begin
						bkt_q  <= 2'd1;
						bsel_q <= 2'd2;
						cur_q  <= bhead_q[2];
					end
					2'd1: begin
						bkt_q  <= 2'd2;
						bsel_q <= 2'd0;
						cur_q  <= bhead_q[0];
					end
					default: begin
						bkt_q  <= 2'd0;
						bsel_q <= 2'd1;
						cur_q  <= bhead_q[1];
					end
				endcase
			end
			if (cmd.ret_commit) begin
				if (fresh_node) begin
					fresh_q <= free_q;
				end
				bhead_q[bkt_q] <= free_q;
				free_q         <= ret_next;
			end
			if (cmd.drain_emit) begin
				free_q <= cur_q;
				cur_q  <= link_rd;
				n_q    <= n_q + 1'b1;
			end
			if (cmd.drain_close) begin
				bhead_q[bsel_q] <= (cur_q >= NULLN) ? NULLN : cur_q;
				if (sts.more) begin
					bsel_q <= bsel_nx;
					cur_q  <= bhead_q[bsel_nx];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit_single || cmd.drain_emit) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_single) begin
			ostat_q <= st_q;
			orv_q   <= 1'b0;
			oh_q    <= '0;
			ot_q    <= '0;
			olast_q <= 1'b1;
			oadv_q  <= adv_q;
			oep_q   <= epoch_q;
			odrop_q <= drop_q;
		end else if (cmd.drain_emit) begin
			ostat_q <= erc_pkg::ST_DONE;
			orv_q   <= 1'b1;
			oh_q    <= data_rd[DW-1:erc_pkg::TAG_W];
			ot_q    <= data_rd[erc_pkg::TAG_W-1:0];
			olast_q <= drain_last;
			oadv_q  <= adv_q;
			oep_q   <= epoch_q;
			odrop_q <= drop_q;
		end
	end

	assign rsp.valid            = ovalid_q;
	assign rsp.status           = ostat_q;
	assign rsp.reclaim_valid    = orv_q;
	assign rsp.reclaimed_handle = oh_q;
	assign rsp.reclaimed_tag    = ot_q;
	assign rsp.last             = olast_q;
	assign rsp.epoch_advanced   = oadv_q;
	assign rsp.current_epoch    = oep_q;
	assign rsp.dropped_count    = odrop_q;

	assign sts.op        = op_q;
	assign sts.ret_alloc = handle_q != '0 && !free_null;
	assign sts.scan_busy = scan_q < SCW'(THREAD_SLOTS) || pend_s1;
	assign sts.blocked   = blocked_q;
	assign sts.live      = cur_q < NULLN && n_q < erc_pkg::NW'(erc_pkg::MAX_RESULTS);
	assign sts.more      = op_q == erc_pkg::OP_SHUTDOWN && bsel_q != 2'd2;
	assign sts.n_zero    = n_q == '0;
	assign sts.out_free  = !ovalid_q || rsp.ready;

	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= erc_pkg::NW'(erc_pkg::MAX_RESULTS))
		else $error("result count beyond limit");
	a_emit_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_emit |-> cur_q < NULLN)
		else $error("reclaim from null node");
	a_ret_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ret_commit |-> !free_null)
		else $error("allocation from empty pool");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !rsp.ready) |-> !(cmd.emit_single || cmd.drain_emit))
		else $error("result register overwritten");
endmodule

FILE: rtl/erc_ctrl.sv
// erc_ctrl: sequencing state machine of the reclamation engine.
// Uses erc_pkg command and status structs.
`timescale 1ns / 1ps

module erc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  erc_pkg::sts_t sts,
	output erc_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_RET   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_FDEC  = 3'd4;
	localparam logic [2:0] S_DCHK  = 3'd5;
	localparam logic [2:0] S_DEMIT = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				priority if (sts.op == erc_pkg::OP_RETIRE && sts.ret_alloc) begin
					state_d = S_RET;
				end else if (sts.op == erc_pkg::OP_FLUSH) begin
					state_d = S_SCAN;
				end else if (sts.op == erc_pkg::OP_SHUTDOWN) begin
					state_d = S_DCHK;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_RET: begin
				cmd.ret_commit = 1'b1;
				state_d        = S_EMIT;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (!sts.scan_busy) begin
					state_d = S_FDEC;
				end
			end
			S_FDEC: begin
				if (sts.blocked) begin
					cmd.set_blocked = 1'b1;
					state_d         = S_EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_DCHK;
				end
			end
			S_DCHK: begin
				if (sts.live) begin
					cmd.drain_rd = 1'b1;
					state_d      = S_DEMIT;
				end else begin
					cmd.drain_close = 1'b1;
					priority if (sts.more) begin
						state_d = S_DCHK;
					end else if (sts.n_zero) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DEMIT: begin
				if (sts.out_free) begin
					cmd.drain_emit = 1'b1;
					state_d        = S_DCHK;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_single = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == S_EXEC)
		else $error("request not executed");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_single && cmd.drain_emit))
		else $error("two results at once");
	a_single_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_single |=> state_q == S_IDLE)
		else $error("single result not followed by idle");
endmodule

FILE: rtl/epoch_reclamation_engine_top.sv
// epoch_reclamation_engine_top: three-epoch reclamation engine, request in, results out.
// Flush scans the announce RAM, then reclaims one node per result and closes the bucket;
// a held result stalls the drain. Shutdown reclaims every bucket; one request at a time.
// Reset clears slot state, epoch, counters and lists at once; no clearing pass.
`timescale 1ns / 1ps

module epoch_reclamation_engine_top #(
	parameter int THREAD_SLOTS = erc_pkg::THREAD_SLOTS_DEF,
	parameter int POOL_NODES   = erc_pkg::POOL_NODES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	erc_req_if.sink   req,
	erc_rsp_if.source rsp
);
	erc_pkg::cmd_t cmd;
	erc_pkg::sts_t sts;
	logic          ready;

	assign req.ready = ready;

	erc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(ready),
		.sts(sts), .cmd(cmd)
	);

	erc_dp #(.THREAD_SLOTS(THREAD_SLOTS), .POOL_NODES(POOL_NODES)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(req.op), .thread_slot(req.thread_slot),
		.handle(req.handle), .cleanup_tag(req.cleanup_tag), .cmd(cmd), .sts(sts),
		.rsp(rsp)
	);
endmodule
